// ===== sv/cds_pkg.sv =====
package cds_pkg;

  // Field widths of the item and result.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 22;
  localparam int DIFF_W   = 23;
  localparam int STAT_W   = 3;
  localparam int STEP_W   = 16;

  // Width of the shared multiplier result (14 by 13 bits).
  localparam int PROD_W   = 27;
  // Year divided by 100 and year modulo 100.
  localparam int YQ_W     = 8;
  localparam int YMOD_W   = 7;

  localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
  localparam logic [SERIAL_W-1:0] SERIAL_MAX = 22'd3652059;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_ONE  = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LONG = 5'd31;
  localparam logic [DAY_W-1:0]   DAY_SHORT = 5'd30;

  // Constants of the serial computation. 5243 / 2^19 is a reciprocal of 100
  // that is exact for every 14-bit operand; a shift by 21 gives division by 400.
  localparam logic [12:0] DAYS_YEAR  = 13'd365;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam int          SHR_100    = 19;
  localparam int          SHR_400    = 21;
  localparam logic [14:0] HUNDRED    = 15'd100;

  // Year-position counters of the two saturation bounds.
  localparam logic [YMOD_W-1:0] YMOD_MAX = 7'd99;
  localparam logic [1:0]        CENT_MAX = 2'd3;
  localparam logic [YMOD_W-1:0] YMOD_MIN = 7'd1;
  localparam logic [1:0]        CENT_MIN = 2'd0;

  typedef enum logic [1:0] {
    CMD_SET,
    CMD_ADD,
    CMD_SUB,
    CMD_DIFF
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_RANGE   = 3'd1,
    STAT_FEB     = 3'd2,
    STAT_SHORT31 = 3'd3,
    STAT_SAT     = 3'd4,
    STAT_NO_DATE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_STEP,
    ST_DONE
  } state_t;

  // What the serial unit hands back for the year it worked on.
  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic                leap;
    logic [YMOD_W-1:0]   yr_mod;
    logic [1:0]          cent_mod;
  } serial_res_t;

  // Gregorian leap rule from year mod 100 and (year / 100) mod 4.
  function automatic logic is_leap(logic [YMOD_W-1:0] yr_mod, logic [1:0] cent_mod);
    is_leap = (yr_mod[1:0] == 2'd0) && ((yr_mod != '0) || (cent_mod == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(logic [MONTH_W-1:0] m, logic leap);
    case (m)
      4'd2:                    days_in = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days_in = DAY_SHORT;
      default:                 days_in = DAY_LONG;
    endcase
  endfunction

  // Days of the months before month m in a common year.
  function automatic logic [8:0] days_before(logic [MONTH_W-1:0] m);
    case (m)
      4'd2:    days_before = 9'd31;
      4'd3:    days_before = 9'd59;
      4'd4:    days_before = 9'd90;
      4'd5:    days_before = 9'd120;
      4'd6:    days_before = 9'd151;
      4'd7:    days_before = 9'd181;
      4'd8:    days_before = 9'd212;
      4'd9:    days_before = 9'd243;
      4'd10:   days_before = 9'd273;
      4'd11:   days_before = 9'd304;
      4'd12:   days_before = 9'd334;
      default: days_before = 9'd0;
    endcase
  endfunction

endpackage

// ===== sv/cds_serial.sv =====
// Serial day number of a date, computed over seven steps on one shared
// multiplier and one shared add/subtract accumulator.
module cds_serial (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cds_pkg::YEAR_W-1:0]        year,
  input  logic [cds_pkg::MONTH_W-1:0]       month,
  input  logic [cds_pkg::DAY_W-1:0]         day,
  output logic                              done,
  output cds_pkg::serial_res_t              res
);

  localparam logic [2:0] STEP_MUL_YEAR = 3'd0;
  localparam logic [2:0] STEP_LOAD     = 3'd1;
  localparam logic [2:0] STEP_CENTURY  = 3'd2;
  localparam logic [2:0] STEP_QUAD     = 3'd3;
  localparam logic [2:0] STEP_FOUR     = 3'd4;
  localparam logic [2:0] STEP_MONTHS   = 3'd5;
  localparam logic [2:0] STEP_DAY      = 3'd6;

  logic                            busy;
  logic [2:0]                      step;
  logic [cds_pkg::PROD_W-1:0]      prod;
  logic [cds_pkg::SERIAL_W-1:0]    acc;
  logic [cds_pkg::YQ_W-1:0]        yq;
  logic                            leap;
  logic [cds_pkg::YMOD_W-1:0]      yr_mod;
  logic [1:0]                      cent_mod;

  logic [cds_pkg::YEAR_W-1:0]      prior;
  logic [cds_pkg::YEAR_W-1:0]      mul_a;
  logic [12:0]                     mul_k;
  logic                            mul_en;
  logic [cds_pkg::SERIAL_W-1:0]    addend;
  logic                            sub;
  logic [14:0]                     hund;
  logic [cds_pkg::YMOD_W-1:0]      yr_mod_calc;

  assign prior = year - cds_pkg::YEAR_W'(1);

  // Year modulo 100 from the registered quotient.
  assign hund        = 15'(yq) * cds_pkg::HUNDRED;
  assign yr_mod_calc = cds_pkg::YMOD_W'({1'b0, year} - hund);

  // Operand selection of the shared multiplier.
  always_comb begin
    mul_a  = prior;
    mul_k  = cds_pkg::DAYS_YEAR;
    mul_en = 1'b0;
    case (step)
      STEP_MUL_YEAR: begin
        mul_en = 1'b1;
      end
      STEP_LOAD: begin
        mul_k  = cds_pkg::RECIP_100;
        mul_en = 1'b1;
      end
      STEP_QUAD: begin
        mul_a  = year;
        mul_k  = cds_pkg::RECIP_100;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Operand selection of the shared accumulator.
  always_comb begin
    addend = '0;
    sub    = 1'b0;
    case (step)
      STEP_CENTURY: begin
        addend = cds_pkg::SERIAL_W'(prod >> cds_pkg::SHR_100);
        sub    = 1'b1;
      end
      STEP_QUAD:    addend = cds_pkg::SERIAL_W'(prod >> cds_pkg::SHR_400);
      STEP_FOUR:    addend = cds_pkg::SERIAL_W'(prior >> 2);
      STEP_MONTHS:  addend = cds_pkg::SERIAL_W'(cds_pkg::days_before(month));
      STEP_DAY: begin
        addend = cds_pkg::SERIAL_W'(day)
               + cds_pkg::SERIAL_W'(leap && (month > cds_pkg::MON_FEB));
      end
      default:      addend = '0;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_MUL_YEAR;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_MUL_YEAR;
      end else if (busy) begin
        if (step == STEP_DAY) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

  // Shared datapath.
  always_ff @(posedge clk) begin
    if (busy) begin
      if (mul_en) begin
        prod <= cds_pkg::PROD_W'(mul_a) * cds_pkg::PROD_W'(mul_k);
      end
      if (step == STEP_LOAD) begin
        acc <= cds_pkg::SERIAL_W'(prod);
      end else if (sub) begin
        acc <= acc - addend;
      end else begin
        acc <= acc + addend;
      end
      if (step == STEP_FOUR) begin
        yq <= cds_pkg::YQ_W'(prod >> cds_pkg::SHR_100);
      end
      if (step == STEP_MONTHS) begin
        yr_mod   <= yr_mod_calc;
        cent_mod <= yq[1:0];
        leap     <= cds_pkg::is_leap(yr_mod_calc, yq[1:0]);
      end
    end
  end

  assign res = '{serial: acc, leap: leap, yr_mod: yr_mod, cent_mod: cent_mod};

endmodule

// ===== sv/calendar_date_stepper.sv =====
// Channel   Dir  Transfer        Contents
// s_*       in   one command     tuser: cmd; tdata: year, month, day, step count
// m_*       out  one result      tdata: date, serial, difference, status
//
// Set and difference run the seven steps of the serial unit. Add and subtract
// walk the date one day per cycle; a saturating step or a command without a
// stored date goes straight to the result.
// Reset is synchronous and leaves no valid date stored.
// One command is worked on at a time; a finished result waits in the output
// register while the next command is accepted, and that command holds its
// result until the output register is free.
module calendar_date_stepper #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year [13:0], month [17:14], day [22:18], step_count [38:23], zero fill
  input  logic [39:0] s_tdata,
  // cmd [1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_year [13:0], out_month [17:14], out_day [22:18], serial_day [44:23],
  // day_difference [67:45], status [70:68], zero fill
  output logic [71:0] m_tdata
);

  localparam int SUM_W = ((COUNT_WIDTH > cds_pkg::SERIAL_W) ? COUNT_WIDTH
                          : cds_pkg::SERIAL_W) + 1;

  cds_pkg::state_t                 state;
  cds_pkg::state_t                 state_next;
  cds_pkg::cmd_t                   cmd;
  logic [cds_pkg::YEAR_W-1:0]      year_q;
  logic [cds_pkg::MONTH_W-1:0]     month_q;
  logic [cds_pkg::DAY_W-1:0]       day_q;
  logic [cds_pkg::YEAR_W-1:0]      cur_year;
  logic [cds_pkg::MONTH_W-1:0]     cur_month;
  logic [cds_pkg::DAY_W-1:0]       cur_day;
  logic [cds_pkg::SERIAL_W-1:0]    cur_serial;
  logic [cds_pkg::YMOD_W-1:0]      yr_mod;
  logic [1:0]                      cent_mod;
  logic [COUNT_WIDTH-1:0]          steps_left;
  logic                            step_up;
  cds_pkg::status_t                stat;
  logic [cds_pkg::DIFF_W-1:0]      diff;

  cds_pkg::cmd_t                   in_cmd;
  logic [COUNT_WIDTH-1:0]          in_count;
  logic                            accept;
  logic                            have_date;
  logic                            go_calc;
  logic                            go_step;
  logic                            add_sat;
  logic                            sub_sat;
  logic [SUM_W-1:0]                sum;
  logic                            unit_start;
  logic                            unit_done;
  cds_pkg::serial_res_t            unit_res;
  logic                            out_load;
  cds_pkg::status_t                chk;

  logic                            leap_cur;
  logic [cds_pkg::DAY_W-1:0]       dim;
  logic [cds_pkg::YEAR_W-1:0]      stp_year;
  logic [cds_pkg::MONTH_W-1:0]     stp_month;
  logic [cds_pkg::DAY_W-1:0]       stp_day;
  logic [cds_pkg::SERIAL_W-1:0]    stp_serial;
  logic [cds_pkg::YMOD_W-1:0]      stp_yr_mod;
  logic [1:0]                      stp_cent_mod;

  assign in_cmd    = cds_pkg::cmd_t'(s_tuser[1:0]);
  assign in_count  = COUNT_WIDTH'(s_tdata[38:23]);
  assign accept    = s_tvalid && s_tready;
  assign have_date = (cur_year != '0);

  // Bounds of add and subtract.
  assign sum     = SUM_W'(cur_serial) + SUM_W'(in_count);
  assign add_sat = (sum > SUM_W'(cds_pkg::SERIAL_MAX));
  assign sub_sat = (SUM_W'(in_count) >= SUM_W'(cur_serial));

  assign go_calc = (in_cmd == cds_pkg::CMD_SET) || ((in_cmd == cds_pkg::CMD_DIFF) && have_date);
  assign go_step = have_date
                && (((in_cmd == cds_pkg::CMD_ADD) && !add_sat)
                 || ((in_cmd == cds_pkg::CMD_SUB) && !sub_sat));

  cds_serial u_serial (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .year  (year_q),
    .month (month_q),
    .day   (day_q),
    .done  (unit_done),
    .res   (unit_res)
  );

  // Validation of the held date, using the leap flag of the serial unit.
  always_comb begin
    if ((year_q == '0) || (year_q > cds_pkg::YEAR_MAX) || (month_q == '0)
        || (month_q > cds_pkg::MON_DEC) || (day_q == '0)) begin
      chk = cds_pkg::STAT_RANGE;
    end else if ((month_q == cds_pkg::MON_FEB)
                 && (day_q > cds_pkg::days_in(cds_pkg::MON_FEB, unit_res.leap))) begin
      chk = cds_pkg::STAT_FEB;
    end else if ((day_q == cds_pkg::DAY_LONG)
                 && (cds_pkg::days_in(month_q, 1'b0) == cds_pkg::DAY_SHORT)) begin
      chk = cds_pkg::STAT_SHORT31;
    end else begin
      chk = cds_pkg::STAT_OK;
    end
  end

  // One day forward or backward from the stored date.
  assign leap_cur = cds_pkg::is_leap(yr_mod, cent_mod);
  assign dim      = cds_pkg::days_in(cur_month, leap_cur);

  always_comb begin
    stp_year     = cur_year;
    stp_month    = cur_month;
    stp_day      = cur_day;
    stp_yr_mod   = yr_mod;
    stp_cent_mod = cent_mod;
    if (step_up) begin
      stp_serial = cur_serial + cds_pkg::SERIAL_W'(1);
      if (cur_day == dim) begin
        stp_day = cds_pkg::DAY_ONE;
        if (cur_month == cds_pkg::MON_DEC) begin
          stp_month = cds_pkg::MON_JAN;
          stp_year  = cur_year + cds_pkg::YEAR_W'(1);
          if (yr_mod == cds_pkg::YMOD_MAX) begin
            stp_yr_mod   = '0;
            stp_cent_mod = cent_mod + 2'd1;
          end else begin
            stp_yr_mod = yr_mod + cds_pkg::YMOD_W'(1);
          end
        end else begin
          stp_month = cur_month + cds_pkg::MONTH_W'(1);
        end
      end else begin
        stp_day = cur_day + cds_pkg::DAY_W'(1);
      end
    end else begin
      stp_serial = cur_serial - cds_pkg::SERIAL_W'(1);
      if (cur_day == cds_pkg::DAY_ONE) begin
        if (cur_month == cds_pkg::MON_JAN) begin
          stp_month = cds_pkg::MON_DEC;
          stp_day   = cds_pkg::DAY_LONG;
          stp_year  = cur_year - cds_pkg::YEAR_W'(1);
          if (yr_mod == '0) begin
            stp_yr_mod   = cds_pkg::YMOD_MAX;
            stp_cent_mod = cent_mod - 2'd1;
          end else begin
            stp_yr_mod = yr_mod - cds_pkg::YMOD_W'(1);
          end
        end else begin
          stp_month = cur_month - cds_pkg::MONTH_W'(1);
          stp_day   = cds_pkg::days_in(cur_month - cds_pkg::MONTH_W'(1), leap_cur);
        end
      end else begin
        stp_day = cur_day - cds_pkg::DAY_W'(1);
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cds_pkg::ST_IDLE: begin
        if (accept) begin
          if (go_calc) begin
            state_next = cds_pkg::ST_CALC;
          end else if (go_step) begin
            state_next = cds_pkg::ST_STEP;
          end else begin
            state_next = cds_pkg::ST_DONE;
          end
        end
      end
      cds_pkg::ST_CALC: begin
        if (unit_done) begin
          state_next = cds_pkg::ST_DONE;
        end
      end
      cds_pkg::ST_STEP: begin
        if (steps_left == '0) begin
          state_next = cds_pkg::ST_DONE;
        end
      end
      cds_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = cds_pkg::ST_IDLE;
        end
      end
      default: state_next = cds_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready   = 1'b0;
    unit_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      cds_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        unit_start = s_tvalid && go_calc;
      end
      cds_pkg::ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stored date and command datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year   <= '0;
      cur_month  <= '0;
      cur_day    <= '0;
      cur_serial <= '0;
      yr_mod     <= '0;
      cent_mod   <= '0;
    end else begin
      case (state)
        cds_pkg::ST_IDLE: begin
          if (accept) begin
            cmd        <= in_cmd;
            year_q     <= s_tdata[13:0];
            month_q    <= s_tdata[17:14];
            day_q      <= s_tdata[22:18];
            steps_left <= in_count;
            step_up    <= (in_cmd == cds_pkg::CMD_ADD);
            stat       <= cds_pkg::STAT_OK;
            diff       <= '0;
            if (in_cmd != cds_pkg::CMD_SET) begin
              if (!have_date) begin
                stat <= cds_pkg::STAT_NO_DATE;
              end else if ((in_cmd == cds_pkg::CMD_ADD) && add_sat) begin
                cur_year   <= cds_pkg::YEAR_MAX;
                cur_month  <= cds_pkg::MON_DEC;
                cur_day    <= cds_pkg::DAY_LONG;
                cur_serial <= cds_pkg::SERIAL_MAX;
                yr_mod     <= cds_pkg::YMOD_MAX;
                cent_mod   <= cds_pkg::CENT_MAX;
                stat       <= cds_pkg::STAT_SAT;
              end else if ((in_cmd == cds_pkg::CMD_SUB) && sub_sat) begin
                cur_year   <= cds_pkg::YEAR_W'(1);
                cur_month  <= cds_pkg::MON_JAN;
                cur_day    <= cds_pkg::DAY_ONE;
                cur_serial <= cds_pkg::SERIAL_W'(1);
                yr_mod     <= cds_pkg::YMOD_MIN;
                cent_mod   <= cds_pkg::CENT_MIN;
                stat       <= cds_pkg::STAT_SAT;
              end
            end
          end
        end
        cds_pkg::ST_CALC: begin
          if (unit_done) begin
            stat <= chk;
            if (cmd == cds_pkg::CMD_SET) begin
              if (chk == cds_pkg::STAT_OK) begin
                cur_year   <= year_q;
                cur_month  <= month_q;
                cur_day    <= day_q;
                cur_serial <= unit_res.serial;
                yr_mod     <= unit_res.yr_mod;
                cent_mod   <= unit_res.cent_mod;
              end else begin
                cur_year   <= '0;
                cur_month  <= '0;
                cur_day    <= '0;
                cur_serial <= '0;
              end
            end else if (chk == cds_pkg::STAT_OK) begin
              diff <= cds_pkg::DIFF_W'(cur_serial) - cds_pkg::DIFF_W'(unit_res.serial);
            end
          end
        end
        cds_pkg::ST_STEP: begin
          if (steps_left != '0) begin
            cur_year   <= stp_year;
            cur_month  <= stp_month;
            cur_day    <= stp_day;
            cur_serial <= stp_serial;
            yr_mod     <= stp_yr_mod;
            cent_mod   <= stp_cent_mod;
            steps_left <= steps_left - COUNT_WIDTH'(1);
          end
        end
        default: begin
          cur_year <= cur_year;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, stat, diff, cur_serial, cur_day, cur_month, cur_year};
    end
  end

endmodule

// ===== sv/cds_check.sv =====
// Port-level checks of the calendar date stepper.
module cds_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Each command keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted in back-to-back cycles");

  // A successful command always leaves a stored date.
  a_ok_has_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[70:68] == cds_pkg::STAT_OK)
    |-> (m_tdata[13:0] != 14'd0) && (m_tdata[44:23] != 22'd0))
    else $error("ok status without a stored date");

  // Without a stored date every other result field is zero.
  a_no_date_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[70:68] == cds_pkg::STAT_NO_DATE) |-> (m_tdata[67:0] == 68'd0))
    else $error("no-date result carries nonzero fields");

  // A nonzero difference only comes with an ok status.
  a_diff_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[67:45] != 23'd0) |-> (m_tdata[70:68] == cds_pkg::STAT_OK))
    else $error("difference reported with an error status");

endmodule

bind calendar_date_stepper cds_check u_cds_check (.*);
